@@ sv/rmq_pkg.sv @@
// Shared types and helper functions for the rotation-matrix-to-quaternion converter.
package rmq_pkg;

   // Which quaternion slot takes the square-root-derived component.
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_W = 2'd3
   } axis_type;

   // Cyclic successor of a diagonal axis: x -> y -> z -> x.
   function automatic logic [1:0] cyc_next(input logic [1:0] axis);
      logic [1:0] nxt;
      case (axis)
         2'd0: nxt = 2'd1;
         2'd1: nxt = 2'd2;
         2'd2: nxt = 2'd0;
         default: nxt = 2'd0;
      endcase
      return nxt;
   endfunction

   // Divider lane that feeds a quaternion slot, given the root slot.
   // Lane 0 goes to w (or x when w holds the root), lane 1 to j, lane 2 to k.
   function automatic logic [1:0] quat_lane(input axis_type sel, input logic [1:0] slot);
      logic [1:0] lane;
      if (sel == AXIS_W) begin
         lane = slot;
      end else if (slot == 2'd3) begin
         lane = 2'd0;
      end else if (slot == cyc_next(sel)) begin
         lane = 2'd1;
      end else begin
         lane = 2'd2;
      end
      return lane;
   endfunction

endpackage

@@ sv/rmq_ifs.sv @@
// Valid/ready channel interfaces for matrix requests and quaternion responses.
interface rmq_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m02;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;
   logic signed [DATA_WIDTH-1:0] m12;
   logic signed [DATA_WIDTH-1:0] m20;
   logic signed [DATA_WIDTH-1:0] m21;
   logic signed [DATA_WIDTH-1:0] m22;
   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quat_x;
   logic signed [DATA_WIDTH-1:0] quat_y;
   logic signed [DATA_WIDTH-1:0] quat_z;
   logic signed [DATA_WIDTH-1:0] quat_w;
   logic                         invalid;
   modport source(output valid, quat_x, quat_y, quat_z, quat_w, invalid, input ready);
   modport sink(input valid, quat_x, quat_y, quat_z, quat_w, invalid, output ready);
endinterface

@@ sv/rotation_matrix_to_quaternion_top.sv @@
// Pipelined fixed-point rotation-matrix-to-quaternion converter.
//
// Each request carries one row-major 3x3 rotation matrix in signed fixed point with
// FRAC_BITS fraction bits and returns one quaternion (x, y, z, w) in the same format.
// The block accepts one request in every cycle and sustains one response per cycle
// while the response side does not stall. RW = (DATA_WIDTH + FRAC_BITS + 5) / 2 is the
// root width (one pipeline stage per root bit) and NW = DATA_WIDTH + FRAC_BITS + 3 is
// the quotient width (one restoring-divider stage per quotient bit); at the default
// 16-bit, 14-fraction-bit format RW is 17 and NW is 33. The whole pipeline
// advances together whenever the response register is empty or being taken, so a
// stall on the response side holds every stage and loses nothing. When the trace is
// positive, w comes from the square root of trace + 1; otherwise the largest diagonal
// entry (ties keep the lower index) selects the root axis. Components are rounded to
// nearest with halves away from zero and saturate to the signed output range. A matrix
// whose square-root argument is not positive returns all-zero components with the
// invalid flag set.
module rotation_matrix_to_quaternion_top #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);

   localparam int DW  = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   // Signed working width for the trace and the square-root argument.
   localparam int SW  = DW + 3;
   // The square-root argument is positive and below 2^(DW+2).
   localparam int AW  = DW + 2;
   // Root width; the radicand is the argument shifted up by F + 2 bits.
   localparam int RW  = (AW + F + 3) / 2;
   localparam int XW  = 2 * RW;
   // Width of the rounding numerator (2 * |D| << F) + r and of the quotient.
   localparam int NW  = DW + F + 3;

   localparam logic [NW-1:0] QMAX = {{(NW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
   localparam logic [NW-1:0] QMIN = {{(NW - DW){1'b0}}, 1'b1, {(DW - 1){1'b0}}};
   localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW - 1){1'b1}}};
   localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW - 1){1'b0}}};
   localparam logic signed [SW-1:0] ONE  = SW'(1) <<< F;

   typedef struct packed {
      logic                  inv;
      rmq_pkg::axis_type     sel;
      logic [2:0][DW:0]      d;
   } sq_pass_type;

   typedef struct packed {
      logic                  inv;
      rmq_pkg::axis_type     sel;
      logic [2:0]            neg;
      logic [RW-1:0]         root;
   } dv_pass_type;

   // The whole pipeline moves when the response register can take a new item.
   logic adv;
   logic rsp_v_ff;
   assign adv = !rsp_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---------------------------------------------------------------------------
   // Entry stage: trace, branch and axis selection, square-root argument, and the
   // three off-diagonal sums or differences that feed the dividers.
   // ---------------------------------------------------------------------------
   logic signed [SW-1:0] mm [3][3];
   logic signed [SW-1:0] trace;
   logic signed [SW-1:0] arg;
   logic signed [SW-1:0] dsum [3];
   logic                 pos;
   logic [1:0]           ai, aj, ak;
   sq_pass_type          s1_pass_in;
   logic [XW-1:0]        s1_x_in;

   always_comb begin
      mm[0][0] = SW'(req_ch.m00);
      mm[0][1] = SW'(req_ch.m01);
      mm[0][2] = SW'(req_ch.m02);
      mm[1][0] = SW'(req_ch.m10);
      mm[1][1] = SW'(req_ch.m11);
      mm[1][2] = SW'(req_ch.m12);
      mm[2][0] = SW'(req_ch.m20);
      mm[2][1] = SW'(req_ch.m21);
      mm[2][2] = SW'(req_ch.m22);
   end

   always_comb begin
      trace = mm[0][0] + mm[1][1] + mm[2][2];
      pos   = trace > 0;
      ai    = 2'd0;
      if (mm[1][1] > mm[0][0]) begin
         ai = 2'd1;
      end
      if (mm[2][2] > ((ai == 2'd1) ? mm[1][1] : mm[0][0])) begin
         ai = 2'd2;
      end
      aj = rmq_pkg::cyc_next(ai);
      ak = rmq_pkg::cyc_next(aj);
      if (pos) begin
         arg     = trace + ONE;
         dsum[0] = mm[2][1] - mm[1][2];
         dsum[1] = mm[0][2] - mm[2][0];
         dsum[2] = mm[1][0] - mm[0][1];
      end else begin
         arg     = mm[ai][ai] - mm[aj][aj] - mm[ak][ak] + ONE;
         dsum[0] = mm[ak][aj] - mm[aj][ak];
         dsum[1] = mm[aj][ai] + mm[ai][aj];
         dsum[2] = mm[ak][ai] + mm[ai][ak];
      end
      s1_pass_in.inv  = !pos && (arg <= 0);
      s1_pass_in.sel  = pos ? rmq_pkg::AXIS_W : rmq_pkg::axis_type'(ai);
      s1_pass_in.d[0] = dsum[0][DW:0];
      s1_pass_in.d[1] = dsum[1][DW:0];
      s1_pass_in.d[2] = dsum[2][DW:0];
      // A non-positive argument never reaches the result, so its radicand is zeroed.
      s1_x_in = s1_pass_in.inv ? '0 : XW'({arg[AW-1:0], {(F + 2){1'b0}}});
   end

   // ---------------------------------------------------------------------------
   // Square root: one result bit per stage, digit by digit. Entry 0 is the entry
   // stage register; entry s + 1 holds the state after s + 1 root bits.
   // ---------------------------------------------------------------------------
   logic          sq_v_ff    [RW+1];
   sq_pass_type   sq_pass_ff [RW+1];
   logic [XW-1:0] sq_x_ff    [RW+1];
   logic [RW:0]   sq_rem_ff  [RW+1];
   logic [RW-1:0] sq_root_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= req_ch.valid;
      end
      if (adv) begin
         sq_pass_ff[0] <= s1_pass_in;
         sq_x_ff[0]    <= s1_x_in;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < RW; s++) begin : g_sqrt
      localparam int P = RW - 1 - s;
      logic [RW+2:0] sq_t;
      logic [RW+2:0] sq_trial;
      logic [RW+2:0] sq_diff;
      logic          sq_ge;
      logic [RW:0]   sq_rem_in;
      logic [RW-1:0] sq_root_in;

      always_comb begin
         sq_t       = {sq_rem_ff[s], sq_x_ff[s][2*P+1 -: 2]};
         sq_trial   = {1'b0, sq_root_ff[s], 2'b01};
         sq_diff    = sq_t - sq_trial;
         sq_ge      = sq_t >= sq_trial;
         sq_rem_in  = sq_ge ? sq_diff[RW:0] : sq_t[RW:0];
         sq_root_in = {sq_root_ff[s][RW-2:0], sq_ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[s+1] <= sq_v_ff[s];
         end
         if (adv) begin
            sq_pass_ff[s+1] <= sq_pass_ff[s];
            sq_x_ff[s+1]    <= sq_x_ff[s];
            sq_rem_ff[s+1]  <= sq_rem_in;
            sq_root_ff[s+1] <= sq_root_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Divider setup: magnitudes, signs and the rounding numerators 2|D|*2^F + r,
   // with divisor 2r, so the quotient is the rounded |D| * 2^F / r.
   // ---------------------------------------------------------------------------
   dv_pass_type          dp_pass_in;
   logic [2:0][NW-1:0]   dp_num_in;
   logic [2:0][DW:0]     dp_mag;
   logic [RW-1:0]        sq_root_last;

   assign sq_root_last = sq_root_ff[RW];

   always_comb begin
      dp_pass_in.inv  = sq_pass_ff[RW].inv;
      dp_pass_in.sel  = sq_pass_ff[RW].sel;
      dp_pass_in.root = sq_root_last;
      for (int l = 0; l < 3; l++) begin
         dp_pass_in.neg[l] = sq_pass_ff[RW].d[l][DW];
         dp_mag[l]         = dp_pass_in.neg[l] ? (DW + 1)'(-sq_pass_ff[RW].d[l])
                                               : sq_pass_ff[RW].d[l];
         dp_num_in[l]      = NW'({dp_mag[l], {(F + 1){1'b0}}}) + NW'(sq_root_last);
      end
   end

   // Entry 0 is the setup register; entry b + 1 holds b + 1 quotient bits.
   logic                 dv_v_ff    [NW+1];
   dv_pass_type          dv_pass_ff [NW+1];
   logic [RW:0]          dv_dvs_ff  [NW+1];
   logic [2:0][NW-1:0]   dv_num_ff  [NW+1];
   logic [2:0][RW:0]     dv_rem_ff  [NW+1];
   logic [2:0][NW-1:0]   dv_q_ff    [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[RW];
      end
      if (adv) begin
         dv_pass_ff[0] <= dp_pass_in;
         dv_dvs_ff[0]  <= {sq_root_last, 1'b0};
         dv_num_ff[0]  <= dp_num_in;
         dv_rem_ff[0]  <= '0;
         dv_q_ff[0]    <= '0;
      end
   end

   for (genvar b = 0; b < NW; b++) begin : g_div
      localparam int BIT = NW - 1 - b;
      logic [2:0][RW:0]   dv_rem_in;
      logic [2:0][NW-1:0] dv_q_in;

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [RW+1:0] dv_t;
         logic [RW+1:0] dv_diff;
         logic          dv_ge;

         always_comb begin
            dv_t         = {dv_rem_ff[b][l], dv_num_ff[b][l][BIT]};
            dv_diff      = dv_t - {1'b0, dv_dvs_ff[b]};
            dv_ge        = dv_t >= {1'b0, dv_dvs_ff[b]};
            dv_rem_in[l] = dv_ge ? dv_diff[RW:0] : dv_t[RW:0];
            dv_q_in[l]   = {dv_q_ff[b][l][NW-2:0], dv_ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[b+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[b+1] <= dv_v_ff[b];
         end
         if (adv) begin
            dv_pass_ff[b+1] <= dv_pass_ff[b];
            dv_dvs_ff[b+1]  <= dv_dvs_ff[b];
            dv_num_ff[b+1]  <= dv_num_ff[b];
            dv_rem_ff[b+1]  <= dv_rem_in;
            dv_q_ff[b+1]    <= dv_q_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output stage: round the root to F fraction bits, sign and saturate the
   // quotients, and route each value to its quaternion slot.
   // ---------------------------------------------------------------------------
   dv_pass_type              fin_pass;
   logic [RW:0]              fin_rc;
   logic signed [DW-1:0]     fin_root;
   logic signed [DW-1:0]     fin_lane [3];
   logic signed [DW-1:0]     rsp_q_in [4];
   logic signed [DW-1:0]     rsp_q_ff [4];
   logic                     rsp_inv_ff;
   logic [NW-1:0]            fin_q;

   assign fin_pass = dv_pass_ff[NW];

   always_comb begin
      fin_rc   = ((RW + 1)'(fin_pass.root) + (RW + 1)'(2)) >> 2;
      fin_root = (NW'(fin_rc) > QMAX) ? SMAX : fin_rc[DW-1:0];
      for (int l = 0; l < 3; l++) begin
         fin_q = dv_q_ff[NW][l];
         if (fin_pass.neg[l]) begin
            fin_lane[l] = (fin_q > QMIN) ? SMIN : DW'(-fin_q);
         end else begin
            fin_lane[l] = (fin_q > QMAX) ? SMAX : fin_q[DW-1:0];
         end
      end
      for (int s = 0; s < 4; s++) begin
         if (fin_pass.inv) begin
            rsp_q_in[s] = '0;
         end else if (2'(s) == fin_pass.sel) begin
            rsp_q_in[s] = fin_root;
         end else begin
            rsp_q_in[s] = fin_lane[rmq_pkg::quat_lane(fin_pass.sel, 2'(s))];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= dv_v_ff[NW];
      end
      if (adv) begin
         rsp_q_ff   <= rsp_q_in;
         rsp_inv_ff <= fin_pass.inv;
      end
   end

   assign rsp_ch.valid   = rsp_v_ff;
   assign rsp_ch.quat_x  = rsp_q_ff[0];
   assign rsp_ch.quat_y  = rsp_q_ff[1];
   assign rsp_ch.quat_z  = rsp_q_ff[2];
   assign rsp_ch.quat_w  = rsp_q_ff[3];
   assign rsp_ch.invalid = rsp_inv_ff;

endmodule

@@ dv/rotation_matrix_to_quaternion_top_tb.sv @@
// Self-checking testbench for the rotation-matrix-to-quaternion converter.
module rotation_matrix_to_quaternion_top_tb;

   localparam int DW     = 16;
   localparam int FB     = 14;
   localparam int ONE    = 1 << FB;
   localparam int N_RAND = 1750;

   // This settle time covers the converter's latency at the default format.
   localparam int SETTLE = 80;

   typedef logic signed [DW-1:0] sample_type;

   // One quaternion as the block reports it.
   typedef struct packed {
      sample_type qx;
      sample_type qy;
      sample_type qz;
      sample_type qw;
      logic       bad;
   } quat_type;

   // One row of the directed table.  When known is set, the quaternion typed in the
   // row is checked against the predictor as well, so the two cannot drift together.
   typedef struct {
      sample_type m[9];
      logic       known;
      quat_type   want;
   } vector_type;

   logic clock;
   logic reset;

   rmq_req_if #(.DATA_WIDTH(DW)) req_if();
   rmq_rsp_if #(.DATA_WIDTH(DW)) rsp_if();

   rotation_matrix_to_quaternion_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Quaternions still owed by the block, oldest first.
   quat_type pending_quats[$];
   int       mismatches;
   int       table_errors;
   logic     calm;   // While set, neither side idles.

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Integer square root by the bit-pair method; floor of the true root.
   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic sample_type clamp(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return sample_type'(v);
   endfunction

   // Rounded quotient d * 2^FB / root with halves away from zero, then clamped.
   function automatic sample_type scaled_ratio(input longint d,
                                               input longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q   = (2 * (mag << FB) + root) / (2 * root);
      return (d < 0) ? clamp(-longint'(q)) : clamp(longint'(q));
   endfunction

   // Works out the quaternion of one matrix, given in row-major order.
   function automatic quat_type convert_matrix(input sample_type m[9]);
      longint          e[3][3];
      longint          comp[4];
      longint          tr;
      longint          arg;
      longint unsigned root;
      int              i;
      int              j;
      int              k;
      quat_type        res;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            e[a][b] = longint'(m[a * 3 + b]);
      res = '0;
      tr  = e[0][0] + e[1][1] + e[2][2];
      if (tr > 0) begin
         root   = int_root(longint'(tr + ONE) << (FB + 2));
         res.qw = clamp(longint'((root + 2) >> 2));
         res.qx = scaled_ratio(e[2][1] - e[1][2], root);
         res.qy = scaled_ratio(e[0][2] - e[2][0], root);
         res.qz = scaled_ratio(e[1][0] - e[0][1], root);
      end else begin
         // Largest diagonal picks the root axis; on a tie the lower index wins.
         i = 0;
         if (e[1][1] > e[0][0]) i = 1;
         if (e[2][2] > e[i][i]) i = 2;
         j   = (i + 1) % 3;
         k   = (j + 1) % 3;
         arg = e[i][i] - e[j][j] - e[k][k] + ONE;
         if (arg <= 0) begin
            res.bad = 1'b1;
         end else begin
            root    = int_root(longint'(arg) << (FB + 2));
            comp[i] = clamp(longint'((root + 2) >> 2));
            comp[3] = scaled_ratio(e[k][j] - e[j][k], root);
            comp[j] = scaled_ratio(e[j][i] + e[i][j], root);
            comp[k] = scaled_ratio(e[k][i] + e[i][k], root);
            res.qx  = sample_type'(comp[0]);
            res.qy  = sample_type'(comp[1]);
            res.qz  = sample_type'(comp[2]);
            res.qw  = sample_type'(comp[3]);
         end
      end
      return res;
   endfunction

   // Presents one matrix and holds it until the block takes it.  Before the request
   // the sender may idle for a few cycles, unless the calm window is open.
   task automatic send_matrix(input sample_type m[9]);
      while (!calm && $urandom_range(99) < 23) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.m00 <= m[0];
      req_if.m01 <= m[1];
      req_if.m02 <= m[2];
      req_if.m10 <= m[3];
      req_if.m11 <= m[4];
      req_if.m12 <= m[5];
      req_if.m20 <= m[6];
      req_if.m21 <= m[7];
      req_if.m22 <= m[8];
      do @(posedge clock); while (!req_if.ready);
      pending_quats.push_back(convert_matrix(m));
   endtask

   // Response side: random back-pressure, except inside the calm window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 23);
      end
   end

   // Every response taken is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      quat_type got;
      quat_type exp_q;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.quat_x, rsp_if.quat_y, rsp_if.quat_z, rsp_if.quat_w, rsp_if.invalid};
         if (pending_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response x=%0d y=%0d z=%0d w=%0d invalid=%0b",
                        got.qx, got.qy, got.qz, got.qw, got.bad);
         end else begin
            exp_q = pending_quats.pop_front();
            if (got !== exp_q) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected x=%0d y=%0d z=%0d w=%0d invalid=%0b,",
                            " got x=%0d y=%0d z=%0d w=%0d invalid=%0b"},
                           exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.bad,
                           got.qx, got.qy, got.qz, got.qw, got.bad);
            end
         end
      end
   end

   // Directed rows, in row-major order m00 m01 m02 m10 m11 m12 m20 m21 m22.
   vector_type directed[$];

   task automatic add_row(input sample_type m[9], input logic known, input quat_type want);
      vector_type v;
      v.m     = m;
      v.known = known;
      v.want  = want;
      directed.push_back(v);
   endtask

   // Random matrix: fully random, small entries, or diagonally dominant so that
   // every root axis and both trace signs turn up often.
   function automatic void random_matrix(output sample_type m[9]);
      int style;
      int hot;
      style = $urandom_range(2);
      hot   = $urandom_range(3);
      for (int n = 0; n < 9; n++) begin
         if (style == 0)
            m[n] = sample_type'($urandom);
         else
            m[n] = sample_type'($signed($urandom_range(2 * ONE)) - ONE);
      end
      if (style == 2) begin
         for (int d = 0; d < 3; d++)
            m[d * 4] = sample_type'(-$signed($urandom_range(ONE)));
         if (hot < 3) m[hot * 4] = sample_type'($urandom_range(32767));
      end
   endfunction

   initial begin
      sample_type m[9];
      quat_type   none;
      none          = '0;
      mismatches    = 0;
      table_errors  = 0;
      calm          = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.m00    = '0;
      req_if.m01    = '0;
      req_if.m02    = '0;
      req_if.m10    = '0;
      req_if.m11    = '0;
      req_if.m12    = '0;
      req_if.m20    = '0;
      req_if.m21    = '0;
      req_if.m22    = '0;
      rsp_if.ready  = 1'b0;

      // Identity: w is exactly one, the rest zero.
      add_row('{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384}, 1'b1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0});
      // Zero matrix: trace is zero, x is picked by the tie rule and equals one half.
      add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
              '{16'sd8192, 16'sd0, 16'sd0, 16'sd0, 1'b0});
      // Extremes of every entry.
      add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, none);
      add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, none);
      add_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, none);
      // Saturating off-diagonal differences against a small root.
      add_row('{0, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 16'sh8000,
                16'sh8000, 16'sh7fff, 0}, 1'b0, none);
      add_row('{16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 16'sh7fff,
                16'sh7fff, 16'sh8000, 0}, 1'b0, none);
      // Each root axis with a non-positive trace, and the ties between them.
      add_row('{16'sd8192, 100, -200, 300, -16384, 400, -500, 600, -16384}, 1'b0, none);
      add_row('{-16384, 100, -200, 300, 16'sd8192, 400, -500, 600, -16384}, 1'b0, none);
      add_row('{-16384, 100, -200, 300, -16384, 400, -500, 600, 16'sd8192}, 1'b0, none);
      add_row('{16'sd4096, -700, 900, 1100, 16'sd4096, -1300, 1500, -1700, 16'sh8000},
              1'b0, none);
      add_row('{16'sh8000, -700, 900, 1100, 16'sd4096, -1300, 1500, -1700, 16'sd4096},
              1'b0, none);
      // Rotations by ninety degrees about each axis.
      add_row('{16'sd16384, 0, 0, 0, 0, -16384, 0, 16'sd16384, 0}, 1'b0, none);
      add_row('{0, 0, 16'sd16384, 0, 16'sd16384, 0, -16384, 0, 0}, 1'b0, none);
      add_row('{0, -16384, 0, 16'sd16384, 0, 0, 0, 0, 16'sd16384}, 1'b0, none);
      // Half turn about x, smallest positive trace, and a trace of exactly zero.
      add_row('{16'sd16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1'b0, none);
      add_row('{16'sd1, 16'sd5, -7, 9, 0, -11, 13, -15, 0}, 1'b0, none);
      add_row('{16'sd10, 16'sd5, -7, 9, -4, -11, 13, -15, -6}, 1'b0, none);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[n]) begin
         if (directed[n].known && convert_matrix(directed[n].m) !== directed[n].want) begin
            table_errors++;
            $display("directed row %0d disagrees with its typed quaternion", n);
         end
         send_matrix(directed[n].m);
      end

      for (int n = 0; n < N_RAND; n++) begin
         // A long stretch with neither side idling.
         calm = (n >= 600 && n < 900);
         // Once, the sender holds back until the pipeline has drained completely.
         if (n == 1100) begin
            req_if.valid <= 1'b0;
            while (pending_quats.size() != 0) @(posedge clock);
         end
         random_matrix(m);
         send_matrix(m);
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;

      while (pending_quats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && table_errors == 0) begin
         $display("PASS rotation_matrix_to_quaternion_top");
      end else begin
         $display("FAIL rotation_matrix_to_quaternion_top");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #(12 * 200000);
      $display("FAIL rotation_matrix_to_quaternion_top");
      $finish;
   end

endmodule
